// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; clock and reset names are passed in by the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/u2u_pkg.sv =====
// types and constants of the utf-8 to ucs-2 decoder
// no dependencies; used through scoped names by every rtl file but assert_macros.svh
package u2u_pkg;

  localparam int MaxResults = 3;

  typedef logic [15:0] code_t;
  typedef logic [1:0]  res_cnt_t;
  typedef logic [0:0]  cfg_idx_t;

  localparam cfg_idx_t REG_REPLACEMENT_CODE = 1'd0;
  localparam cfg_idx_t REG_STRIP_BOM        = 1'd1;

  localparam code_t REPLACEMENT_RESET = 16'd63;
  localparam code_t BOM_CODE          = 16'hFEFF;

  // results of one byte, slot 0 goes out first
  typedef struct packed {
    res_cnt_t                   cnt;
    logic                       term;
    logic [MaxResults-1:0][15:0] code;
  } bundle_t;

  typedef struct packed {
    code_t replacement_code;
    logic  strip_bom;
  } cfg_t;

endpackage

// ===== rtl/u2u_if.sv =====
// valid/ready channel interfaces for the byte input and code unit output
// depends on u2u_pkg
interface u2u_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_string;

  modport source (output valid, output byte_value, output end_of_string, input ready);
  modport sink   (input valid, input byte_value, input end_of_string, output ready);
endinterface

interface u2u_unit_if;
  logic           valid;
  logic           ready;
  u2u_pkg::code_t code_unit;
  logic           last_of_string;

  modport source (output valid, output code_unit, output last_of_string, input ready);
  modport sink   (input valid, input code_unit, input last_of_string, output ready);
endinterface

// ===== rtl/u2u_front.sv =====
// front end: accepts bytes, tracks per-string state and builds result bundles
// depends on u2u_pkg
module u2u_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte_value,
  input  logic             in_end_of_string,
  input  u2u_pkg::cfg_t    cfg,
  input  logic             q_full,
  output logic             push,
  output u2u_pkg::bundle_t push_data
);

  logic [15:0] pc_r, pc_nxt;
  logic [1:0]  need_r, need_nxt;
  logic        first_r, first_nxt;
  logic [1:0]  bis_r, bis_nxt;

  logic        accept;
  logic        cont;
  logic        is_bom;
  logic [15:0] shifted;
  logic [1:0]  n;
  logic [u2u_pkg::MaxResults-1:0][15:0] codes;
  logic        term;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cont     = (in_byte_value[7:6] == 2'b10);

  always_comb begin
    pc_nxt    = pc_r;
    need_nxt  = need_r;
    first_nxt = first_r;
    n         = 2'd0;
    codes     = '0;
    term      = 1'b0;
    is_bom    = 1'b0;
    shifted   = (need_r == 2'd2) ? {4'b0, in_byte_value[5:0], 6'b0}
                                 : {10'b0, in_byte_value[5:0]};
    if (cont) begin
      if (need_r != 2'd0) begin
        pc_nxt   = pc_r | shifted;
        need_nxt = need_r - 2'd1;
        if (need_nxt == 2'd0) begin
          is_bom = cfg.strip_bom && first_r && (bis_r == 2'd2) &&
                   (pc_nxt == u2u_pkg::BOM_CODE);
          if (!is_bom) begin
            codes[n] = pc_nxt;
            n        = n + 2'd1;
          end
          first_nxt = 1'b0;
          pc_nxt    = '0;
        end
      end
    end else begin
      // cut-short sequence goes out with missing bits zero
      if (need_r != 2'd0) begin
        codes[n]  = pc_r;
        n         = n + 2'd1;
        need_nxt  = 2'd0;
        pc_nxt    = '0;
        first_nxt = 1'b0;
      end
      if (!in_byte_value[7]) begin
        codes[n]  = {8'b0, in_byte_value};
        n         = n + 2'd1;
        first_nxt = 1'b0;
      end else if (in_byte_value[7:5] == 3'b110) begin
        pc_nxt   = {5'b0, in_byte_value[4:0], 6'b0};
        need_nxt = 2'd1;
      end else if (in_byte_value[7:4] == 4'b1110) begin
        pc_nxt   = {in_byte_value[3:0], 12'b0};
        need_nxt = 2'd2;
      end else begin
        codes[n]  = cfg.replacement_code;
        n         = n + 2'd1;
        first_nxt = 1'b0;
      end
    end

    bis_nxt = (bis_r == 2'd3) ? 2'd3 : bis_r + 2'd1;

    if (in_end_of_string) begin
      if (need_nxt != 2'd0) begin
        codes[n] = pc_nxt;
        n        = n + 2'd1;
      end
      codes[n]  = '0;
      n         = n + 2'd1;
      term      = 1'b1;
      pc_nxt    = '0;
      need_nxt  = 2'd0;
      first_nxt = 1'b1;
      bis_nxt   = 2'd0;
    end
  end

  assign push           = accept && (n != 2'd0);
  assign push_data.cnt  = n;
  assign push_data.term = term;
  assign push_data.code = codes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      need_r  <= 2'd0;
      first_r <= 1'b1;
      bis_r   <= 2'd0;
    end else if (accept) begin
      pc_r    <= pc_nxt;
      need_r  <= need_nxt;
      first_r <= first_nxt;
      bis_r   <= bis_nxt;
    end
  end

endmodule

// ===== rtl/u2u_queue.sv =====
// two-entry bundle queue between front and back end
// depends on u2u_pkg
module u2u_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  u2u_pkg::bundle_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output u2u_pkg::bundle_t rd_data
);

  u2u_pkg::bundle_t mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_wr;
  logic       do_rd;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) begin
        wp_r <= !wp_r;
      end
      if (do_rd) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// ===== rtl/u2u_back.sv =====
// back end: serializes each bundle into code units through an output register
// depends on u2u_pkg
module u2u_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  u2u_pkg::bundle_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output u2u_pkg::code_t   out_code_unit,
  output logic             out_last_of_string
);

  logic           valid_r;
  u2u_pkg::code_t code_r;
  logic           last_r;
  logic [1:0]     idx_r;
  logic           load;
  logic           at_end;
  u2u_pkg::code_t sel_code;

  always_comb begin
    case (idx_r)
      2'd0:    sel_code = q_data.code[0];
      2'd1:    sel_code = q_data.code[1];
      2'd2:    sel_code = q_data.code[2];
      default: sel_code = '0;
    endcase
  end

  assign load   = q_valid && (!valid_r || out_ready);
  assign at_end = (idx_r == q_data.cnt - 2'd1);
  assign q_pop  = load && at_end;

  assign out_valid          = valid_r;
  assign out_code_unit      = code_r;
  assign out_last_of_string = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= sel_code;
      last_r <= q_data.term && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_end ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/utf8_to_ucs2_decoder.sv =====
// UTF-8 bytes in, UCS-2 code units out. A byte is taken every cycle while
// the two-bundle queue between the decode front end and the output
// serializer has room. A byte yields 0 to 3 code units (a cut-short
// sequence flush, the character itself, the terminator); the serializer
// moves one code unit per cycle through its output register while the
// output is ready, so the sustained rate is one byte per cycle as long as
// bytes average one unit. A byte's first code unit passes through a queue
// entry and then the output register.
// depends on u2u_pkg, u2u_if, u2u_front, u2u_queue, u2u_back
module utf8_to_ucs2_decoder (
  input  logic                clk,
  input  logic                rst_n,
  u2u_byte_if.sink            in_byte,
  u2u_unit_if.source          out_unit,
  input  logic                cfg_we,
  input  u2u_pkg::cfg_idx_t   cfg_index,
  input  logic [15:0]         cfg_wdata
);

  u2u_pkg::cfg_t    cfg_r;
  logic             q_full;
  logic             push;
  u2u_pkg::bundle_t push_data;
  logic             q_pop;
  logic             q_valid;
  u2u_pkg::bundle_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.replacement_code <= u2u_pkg::REPLACEMENT_RESET;
      cfg_r.strip_bom        <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        u2u_pkg::REG_REPLACEMENT_CODE: cfg_r.replacement_code <= cfg_wdata;
        u2u_pkg::REG_STRIP_BOM:        cfg_r.strip_bom        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  u2u_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_byte.valid),
    .in_ready         (in_byte.ready),
    .in_byte_value    (in_byte.byte_value),
    .in_end_of_string (in_byte.end_of_string),
    .cfg              (cfg_r),
    .q_full           (q_full),
    .push             (push),
    .push_data        (push_data)
  );

  u2u_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (push_data),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  u2u_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_data             (q_data),
    .q_pop              (q_pop),
    .out_valid          (out_unit.valid),
    .out_ready          (out_unit.ready),
    .out_code_unit      (out_unit.code_unit),
    .out_last_of_string (out_unit.last_of_string)
  );

endmodule

// ===== rtl/u2u_checker.sv =====
// port-level checks of the decoder, attached to the top level by bind
// depends on assert_macros.svh and u2u_pkg
`include "assert_macros.svh"

module u2u_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input u2u_pkg::code_t out_code_unit,
  input logic           out_last_of_string
);

  // stalled output item holds
  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_code_unit) && $stable(out_last_of_string), "output item changed while stalled")

  // terminator is always a zero code unit
  `ASSERT_CLKD(a_term_zero, clk, rst_n, out_valid && out_last_of_string |-> out_code_unit == 16'd0, "terminator not zero")

  // reset leaves output empty and input open
  `ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> !out_valid && in_ready, "bad state after reset")

endmodule

bind utf8_to_ucs2_decoder u2u_checker u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_byte.ready),
  .out_valid          (out_unit.valid),
  .out_ready          (out_unit.ready),
  .out_code_unit      (out_unit.code_unit),
  .out_last_of_string (out_unit.last_of_string)
);
